FILE: design/midi_drum_trigger_pulser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the drum trigger pulser
// Shared property templates for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef MIDI_DRUM_TRIGGER_PULSER_ASSERT_SVH
`define MIDI_DRUM_TRIGGER_PULSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MDTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("drum trigger pulser check failed");

// Next-cycle implication, disabled while reset is held.
`define MDTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("drum trigger pulser check failed");

`endif

FILE: design/mdtp_pkg.sv
// ----------------------------------------------------------------------------
// Drum trigger pulser package
// Widths, codes, the note table and the command format shared by all parts.
// ----------------------------------------------------------------------------
`default_nettype none

package mdtp_pkg;

    // Field and state widths.
    localparam int TIME_BITS   = 32;
    localparam int NUM_LANES   = 8;
    localparam int LANE_W      = 3;
    localparam int HOLD_W      = 20;
    localparam int LOCK_W      = HOLD_W + 1;
    localparam int MIDI_W      = 7;
    localparam int OPCODE_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = HOLD_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input opcodes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_CONTROL  = 2'd1,
        OP_TICK     = 2'd2,
        OP_RESERVED = 2'd3
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KICK_HOLD      = 3'd0,
        CFG_KICK_HOLDOFF   = 3'd1,
        CFG_PAD_HOLD       = 3'd2,
        CFG_PAD_HOLDOFF    = 3'd3,
        CFG_CYM_HOLD       = 3'd4,
        CFG_CYM_HOLDOFF    = 3'd5,
        CFG_PEDAL_LOW      = 3'd6,
        CFG_PEDAL_HIGH     = 3'd7
    } t_cfg_index;

    // Register reset values.
    localparam logic [HOLD_W-1:0] RST_KICK_HOLD    = HOLD_W'(60000);
    localparam logic [HOLD_W-1:0] RST_KICK_HOLDOFF = HOLD_W'(50000);
    localparam logic [HOLD_W-1:0] RST_PAD_HOLD     = HOLD_W'(1000);
    localparam logic [HOLD_W-1:0] RST_PAD_HOLDOFF  = HOLD_W'(40000);
    localparam logic [HOLD_W-1:0] RST_CYM_HOLD     = HOLD_W'(25000);
    localparam logic [HOLD_W-1:0] RST_CYM_HOLDOFF  = HOLD_W'(40000);
    localparam logic [MIDI_W-1:0] RST_PEDAL_LOW    = MIDI_W'(40);
    localparam logic [MIDI_W-1:0] RST_PEDAL_HIGH   = MIDI_W'(90);

    // Lane numbers.
    localparam logic [LANE_W-1:0] LANE_KICK       = 3'd0;
    localparam logic [LANE_W-1:0] LANE_RED_PAD    = 3'd1;
    localparam logic [LANE_W-1:0] LANE_YELLOW_PAD = 3'd2;
    localparam logic [LANE_W-1:0] LANE_BLUE_PAD   = 3'd3;
    localparam logic [LANE_W-1:0] LANE_GREEN_PAD  = 3'd4;
    localparam logic [LANE_W-1:0] LANE_YELLOW_CYM = 3'd5;
    localparam logic [LANE_W-1:0] LANE_BLUE_CYM   = 3'd6;
    localparam logic [LANE_W-1:0] LANE_GREEN_CYM  = 3'd7;

    // Note numbers with a meaning.
    localparam logic [MIDI_W-1:0] NOTE_KICK       = 7'd36;
    localparam logic [MIDI_W-1:0] NOTE_RED_A      = 7'd38;
    localparam logic [MIDI_W-1:0] NOTE_RED_B      = 7'd40;
    localparam logic [MIDI_W-1:0] NOTE_YELLOW_PAD = 7'd48;
    localparam logic [MIDI_W-1:0] NOTE_BLUE_PAD   = 7'd45;
    localparam logic [MIDI_W-1:0] NOTE_GREEN_PAD  = 7'd43;
    localparam logic [MIDI_W-1:0] NOTE_HIHAT_A    = 7'd26;
    localparam logic [MIDI_W-1:0] NOTE_HIHAT_B    = 7'd46;
    localparam logic [MIDI_W-1:0] NOTE_GREEN_A    = 7'd49;
    localparam logic [MIDI_W-1:0] NOTE_GREEN_B    = 7'd52;
    localparam logic [MIDI_W-1:0] NOTE_GREEN_C    = 7'd55;
    localparam logic [MIDI_W-1:0] NOTE_GREEN_D    = 7'd57;
    localparam logic [MIDI_W-1:0] NOTE_BLUE_A     = 7'd51;
    localparam logic [MIDI_W-1:0] NOTE_BLUE_B     = 7'd53;
    localparam logic [MIDI_W-1:0] NOTE_BLUE_C     = 7'd59;
    localparam logic [MIDI_W-1:0] NOTE_TOGGLE     = 7'd41;

    // The only controller that acts.
    localparam logic [MIDI_W-1:0] CTL_PEDAL = 7'd1;

    // Classified work for the back end.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_STRIKE,
        CMD_HIHAT,
        CMD_TOGGLE,
        CMD_PEDAL,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [LANE_W-1:0]   lane;
        logic [MIDI_W-1:0]   value;
    } t_cmd;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Turn one input beat into a command.
    function automatic t_cmd classify(
        input t_opcode            opcode,
        input logic [MIDI_W-1:0]  note,
        input logic [MIDI_W-1:0]  ctl,
        input logic [MIDI_W-1:0]  val
    );
        t_cmd c;
        c.kind  = CMD_NONE;
        c.lane  = LANE_KICK;
        c.value = val;
        unique case (opcode)
            OP_NOTE_ON: begin
                unique case (note)
                    NOTE_KICK: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_KICK;
                    end
                    NOTE_RED_A, NOTE_RED_B: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_RED_PAD;
                    end
                    NOTE_YELLOW_PAD: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_YELLOW_PAD;
                    end
                    NOTE_BLUE_PAD: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_BLUE_PAD;
                    end
                    NOTE_GREEN_PAD: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_GREEN_PAD;
                    end
                    NOTE_HIHAT_A, NOTE_HIHAT_B: begin
                        c.kind = CMD_HIHAT;
                    end
                    NOTE_GREEN_A, NOTE_GREEN_B, NOTE_GREEN_C, NOTE_GREEN_D: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_GREEN_CYM;
                    end
                    NOTE_BLUE_A, NOTE_BLUE_B, NOTE_BLUE_C: begin
                        c.kind = CMD_STRIKE; c.lane = LANE_BLUE_CYM;
                    end
                    NOTE_TOGGLE: begin
                        c.kind = CMD_TOGGLE;
                    end
                    default: begin
                        c.kind = CMD_NONE;
                    end
                endcase
            end
            OP_CONTROL: begin
                c.kind = (ctl == CTL_PEDAL) ? CMD_PEDAL : CMD_NONE;
            end
            OP_TICK: begin
                c.kind = CMD_TICK;
            end
            default: begin
                c.kind = CMD_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/mdtp_in_if.sv
// ----------------------------------------------------------------------------
// Drum event channel
// Valid/ready channel that carries one drum event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdtp_in_if;
    import mdtp_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [MIDI_W-1:0]   note_number;
    logic [MIDI_W-1:0]   control_number;
    logic [MIDI_W-1:0]   control_value;

    modport source (
        output valid, opcode, note_number, control_number, control_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, note_number, control_number, control_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/mdtp_out_if.sv
// ----------------------------------------------------------------------------
// Lane status channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdtp_out_if;
    import mdtp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [NUM_LANES-1:0] lane_levels;
    logic                 fired;
    logic                 hihat_open;
    logic                 hihat_switch_on;

    modport source (
        output valid, lane_levels, fired, hihat_open, hihat_switch_on,
        input  ready
    );
    modport sink (
        input  valid, lane_levels, fired, hihat_open, hihat_switch_on,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/mdtp_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdtp_cfg_if;
    import mdtp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/mdtp_front.sv
// ----------------------------------------------------------------------------
// Drum trigger pulser front end
// Accepts event beats and turns each one into a command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_front (
    mdtp_in_if.sink              i_in,
    input  mdtp_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output mdtp_pkg::t_cmd       o_cmd
);
    import mdtp_pkg::*;

    // Take a beat whenever the queue has room.
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    // Decode the opcode and the note table.
    always_comb begin
        o_cmd = classify(t_opcode'(i_in.opcode), i_in.note_number,
                         i_in.control_number, i_in.control_value);
    end

endmodule

`default_nettype wire

FILE: design/mdtp_queue.sv
// ----------------------------------------------------------------------------
// Drum trigger pulser command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mdtp_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output mdtp_pkg::t_cmd       o_cmd,
    output mdtp_pkg::t_q_status  o_status
);
    import mdtp_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: design/mdtp_back.sv
// ----------------------------------------------------------------------------
// Drum trigger pulser back end
// Holds the timing registers and lane state, runs one command per cycle
// while its output register is free or draining, and keeps the result there.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mdtp_cfg_if.sink             i_cfg,
    input  mdtp_pkg::t_cmd       i_cmd,
    input  mdtp_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    mdtp_out_if.source           o_out
);
    import mdtp_pkg::*;

    // Configuration; the lockout sums are kept ready beside the raw values.
    logic [HOLD_W-1:0] r_kick_hold, r_kick_holdoff;
    logic [HOLD_W-1:0] r_pad_hold, r_pad_holdoff;
    logic [HOLD_W-1:0] r_cym_hold, r_cym_holdoff;
    logic [LOCK_W-1:0] r_kick_lock, r_pad_lock, r_cym_lock;
    logic [MIDI_W-1:0] r_ped_lo, r_ped_hi;

    // Lane and hi-hat state.
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_fire_time [NUM_LANES];
    logic [NUM_LANES-1:0] r_active, n_active;
    logic                 r_hh_open, n_hh_open;
    logic                 r_hh_switch, n_hh_switch;

    // Output register.
    logic                 r_out_valid;
    logic [NUM_LANES-1:0] r_levels;
    logic                 r_fired, n_fired;
    logic                 r_out_open;
    logic                 r_out_switch;

    logic [TIME_BITS-1:0] hold_of [NUM_LANES];
    logic [TIME_BITS-1:0] lock_of [NUM_LANES];
    logic [LANE_W-1:0]    strike_lane;
    logic [TIME_BITS-1:0] strike_diff;
    logic                 strike_ok;
    logic [TIME_BITS-1:0] now_inc;
    logic [NUM_LANES-1:0] release_lane;
    logic                 n_write_fire;

    assign i_cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick_hold    <= RST_KICK_HOLD;
            r_kick_holdoff <= RST_KICK_HOLDOFF;
            r_pad_hold     <= RST_PAD_HOLD;
            r_pad_holdoff  <= RST_PAD_HOLDOFF;
            r_cym_hold     <= RST_CYM_HOLD;
            r_cym_holdoff  <= RST_CYM_HOLDOFF;
            r_kick_lock    <= LOCK_W'(RST_KICK_HOLD) + LOCK_W'(RST_KICK_HOLDOFF);
            r_pad_lock     <= LOCK_W'(RST_PAD_HOLD) + LOCK_W'(RST_PAD_HOLDOFF);
            r_cym_lock     <= LOCK_W'(RST_CYM_HOLD) + LOCK_W'(RST_CYM_HOLDOFF);
            r_ped_lo       <= RST_PEDAL_LOW;
            r_ped_hi       <= RST_PEDAL_HIGH;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_index'(i_cfg.index))
                CFG_KICK_HOLD: begin
                    r_kick_hold <= i_cfg.data;
                    r_kick_lock <= LOCK_W'(i_cfg.data) + LOCK_W'(r_kick_holdoff);
                end
                CFG_KICK_HOLDOFF: begin
                    r_kick_holdoff <= i_cfg.data;
                    r_kick_lock    <= LOCK_W'(r_kick_hold) + LOCK_W'(i_cfg.data);
                end
                CFG_PAD_HOLD: begin
                    r_pad_hold <= i_cfg.data;
                    r_pad_lock <= LOCK_W'(i_cfg.data) + LOCK_W'(r_pad_holdoff);
                end
                CFG_PAD_HOLDOFF: begin
                    r_pad_holdoff <= i_cfg.data;
                    r_pad_lock    <= LOCK_W'(r_pad_hold) + LOCK_W'(i_cfg.data);
                end
                CFG_CYM_HOLD: begin
                    r_cym_hold <= i_cfg.data;
                    r_cym_lock <= LOCK_W'(i_cfg.data) + LOCK_W'(r_cym_holdoff);
                end
                CFG_CYM_HOLDOFF: begin
                    r_cym_holdoff <= i_cfg.data;
                    r_cym_lock    <= LOCK_W'(r_cym_hold) + LOCK_W'(i_cfg.data);
                end
                CFG_PEDAL_LOW: begin
                    r_ped_lo <= i_cfg.data[MIDI_W-1:0];
                end
                CFG_PEDAL_HIGH: begin
                    r_ped_hi <= i_cfg.data[MIDI_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Per-lane hold and lockout, widened to the time base.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (LANE_W'(i) == LANE_KICK) begin
                hold_of[i] = TIME_BITS'(r_kick_hold);
                lock_of[i] = TIME_BITS'(r_kick_lock);
            end else if (LANE_W'(i) <= LANE_GREEN_PAD) begin
                hold_of[i] = TIME_BITS'(r_pad_hold);
                lock_of[i] = TIME_BITS'(r_pad_lock);
            end else begin
                hold_of[i] = TIME_BITS'(r_cym_hold);
                lock_of[i] = TIME_BITS'(r_cym_lock);
            end
        end
    end

    // Strike test: the hi-hat notes steer between the two cymbals.
    always_comb begin
        if (i_cmd.kind == CMD_HIHAT) begin
            strike_lane = (r_hh_switch && r_hh_open) ? LANE_BLUE_CYM : LANE_YELLOW_CYM;
        end else begin
            strike_lane = i_cmd.lane;
        end
        strike_diff = r_now - r_fire_time[strike_lane];
        strike_ok   = strike_diff > lock_of[strike_lane];
    end

    // Release test against the advanced counter, all lanes in parallel.
    assign now_inc = r_now + 1'b1;
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            release_lane[i] = r_active[i] && ((now_inc - r_fire_time[i]) > hold_of[i]);
        end
    end

    // Take a command whenever the output register is free or being drained.
    assign o_pop = !i_q_status.empty && (!r_out_valid || o_out.ready);

    // Next state for the command at the head of the queue.
    always_comb begin
        n_now        = r_now;
        n_active     = r_active;
        n_hh_open    = r_hh_open;
        n_hh_switch  = r_hh_switch;
        n_fired      = 1'b0;
        n_write_fire = 1'b0;
        unique case (i_cmd.kind)
            CMD_STRIKE, CMD_HIHAT: begin
                if (strike_ok) begin
                    n_active[strike_lane] = 1'b1;
                    n_fired               = 1'b1;
                    n_write_fire          = 1'b1;
                end
            end
            CMD_TOGGLE: begin
                n_hh_switch = !r_hh_switch;
            end
            CMD_PEDAL: begin
                if (r_hh_open && (i_cmd.value >= r_ped_hi)) begin
                    n_hh_open = 1'b0;
                end else if (!r_hh_open && (i_cmd.value <= r_ped_lo)) begin
                    n_hh_open = 1'b1;
                end
            end
            CMD_TICK: begin
                n_now    = now_inc;
                n_active = r_active & ~release_lane;
            end
            default: begin
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_active    <= '0;
            r_hh_open   <= 1'b0;
            r_hh_switch <= 1'b1;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_fire_time[i] <= '0;
            end
        end else if (o_pop) begin
            r_now       <= n_now;
            r_active    <= n_active;
            r_hh_open   <= n_hh_open;
            r_hh_switch <= n_hh_switch;
            if (n_write_fire) begin
                r_fire_time[strike_lane] <= r_now;
            end
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_pop || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_levels     <= n_active;
            r_fired      <= n_fired;
            r_out_open   <= n_hh_open;
            r_out_switch <= n_hh_switch;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.lane_levels     = r_levels;
    assign o_out.fired           = r_fired;
    assign o_out.hihat_open      = r_out_open;
    assign o_out.hihat_switch_on = r_out_switch;

endmodule

`default_nettype wire

FILE: design/midi_drum_trigger_pulser.sv
// ----------------------------------------------------------------------------
// MIDI drum trigger pulser
// Maps drum events to eight trigger lanes with hold and lockout timing.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one event per beat: note-on, control change or a
//   one-microsecond tick. o_out returns one result beat per event with the
//   lane levels after the event, a fired flag and the hi-hat state.
//   i_cfg writes the hold, hold-off and pedal threshold registers; it is
//   always ready and should only be used while no event is in flight.
//   An accepted event waits in the command queue until the back end takes it
//   and registers its result. One event is taken every cycle while results
//   drain; the back end, running one command per cycle, sets the rate.
//   A two-entry command queue sits between decode and execution, and the
//   output register drains at the same time as the next command runs.
//   If the receiver stalls, the result holds, the queue fills and i_in
//   drops ready once both entries are taken.
//   Reset restores the register defaults, clears the counter, fire times
//   and lanes, closes the hi-hat and turns the hi-hat switch on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_drum_trigger_pulser_assert.svh"

module midi_drum_trigger_pulser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdtp_in_if.sink     i_in,
    mdtp_cfg_if.sink    i_cfg,
    mdtp_out_if.source  o_out
);
    import mdtp_pkg::*;

    logic      push;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;

    // Decode side.
    mdtp_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Command queue.
    mdtp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    // Execution side.
    mdtp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_cmd      (queue_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

    // A full queue must hold off the event channel.
    `MDTP_ASSERT_IMP(a_full_blocks_input, i_clk, i_rst_n, q_status.full, !i_in.ready)
    // The back end never runs a command from an empty queue.
    `MDTP_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, pop, !q_status.empty)
    // A fired result always shows at least one lane high.
    `MDTP_ASSERT_IMP(a_fired_lane_high, i_clk, i_rst_n, o_out.valid && o_out.fired, o_out.lane_levels != '0)
    // A command taken while the output is free yields a result next cycle.
    `MDTP_ASSERT_NXT(a_pop_gives_result, i_clk, i_rst_n, pop, o_out.valid)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Drum trigger pulser testbench
// Drives note-on, control change and tick beats into the pulser and checks
// every result beat against a predictor of the lanes, the lockout timing and
// the hi-hat state. The run moves through several register settings,
// including the extremes, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import mdtp_pkg::*;

    // Run control constants.
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_BEATS   = 205;

    // Hold groups that share a register pair.
    localparam int GRP_KICK = 0;
    localparam int GRP_PAD  = 1;
    localparam int GRP_CYM  = 2;

    typedef struct packed {
        t_opcode           opcode;
        logic [MIDI_W-1:0] note;
        logic [MIDI_W-1:0] ctl;
        logic [MIDI_W-1:0] val;
    } t_drum_event;

    typedef struct packed {
        logic [NUM_LANES-1:0] lane_levels;
        logic                 fired;
        logic                 hihat_open;
        logic                 hihat_switch_on;
    } t_lane_status;

    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_STRIKE,
        ROLE_HIHAT,
        ROLE_TOGGLE
    } t_note_role;

    logic i_clk;
    logic i_rst_n;

    mdtp_in_if  in_if ();
    mdtp_out_if out_if ();
    mdtp_cfg_if cfg_if ();

    midi_drum_trigger_pulser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Stimulus and expectation stores.
    t_drum_event  pending_events [$];
    t_lane_status expected_status [$];

    // Predicted kit state and register copies.
    logic [TIME_BITS-1:0] kit_now;
    logic [TIME_BITS-1:0] kit_fire_time [NUM_LANES];
    logic [NUM_LANES-1:0] kit_active;
    logic                 kit_hihat_open;
    logic                 kit_switch_on;
    logic [HOLD_W-1:0]    hold_us [3];
    logic [HOLD_W-1:0]    holdoff_us [3];
    logic [MIDI_W-1:0]    pedal_low;
    logic [MIDI_W-1:0]    pedal_high;

    // Handshake bookkeeping shared between the clocked processes.
    bit tx_idling;
    bit rx_idling;
    bit in_beat_taken;
    int tx_gap_left;
    int rx_stall_left;
    int rx_hold_asks;
    int rx_hold_served;
    int mismatch_count;
    int result_count;

    logic [MIDI_W-1:0] kit_notes [16] = '{
        NOTE_KICK, NOTE_RED_A, NOTE_RED_B, NOTE_YELLOW_PAD, NOTE_BLUE_PAD,
        NOTE_GREEN_PAD, NOTE_HIHAT_A, NOTE_HIHAT_B, NOTE_GREEN_A, NOTE_GREEN_B,
        NOTE_GREEN_C, NOTE_GREEN_D, NOTE_BLUE_A, NOTE_BLUE_B, NOTE_BLUE_C,
        NOTE_TOGGLE
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 result_count, what, got, want);
    endtask

    // Map a note number to what it does to the kit.
    function automatic t_note_role note_role(input logic [MIDI_W-1:0] note,
                                             output logic [LANE_W-1:0] lane);
        lane = LANE_KICK;
        case (note)
            NOTE_KICK: begin
                return ROLE_STRIKE;
            end
            NOTE_RED_A, NOTE_RED_B: begin
                lane = LANE_RED_PAD;
                return ROLE_STRIKE;
            end
            NOTE_YELLOW_PAD: begin
                lane = LANE_YELLOW_PAD;
                return ROLE_STRIKE;
            end
            NOTE_BLUE_PAD: begin
                lane = LANE_BLUE_PAD;
                return ROLE_STRIKE;
            end
            NOTE_GREEN_PAD: begin
                lane = LANE_GREEN_PAD;
                return ROLE_STRIKE;
            end
            NOTE_GREEN_A, NOTE_GREEN_B, NOTE_GREEN_C, NOTE_GREEN_D: begin
                lane = LANE_GREEN_CYM;
                return ROLE_STRIKE;
            end
            NOTE_BLUE_A, NOTE_BLUE_B, NOTE_BLUE_C: begin
                lane = LANE_BLUE_CYM;
                return ROLE_STRIKE;
            end
            NOTE_HIHAT_A, NOTE_HIHAT_B: begin
                return ROLE_HIHAT;
            end
            NOTE_TOGGLE: begin
                return ROLE_TOGGLE;
            end
            default: begin
                return ROLE_NONE;
            end
        endcase
    endfunction

    function automatic int hold_group(input int lane);
        if (lane == LANE_KICK) return GRP_KICK;
        if (lane <= LANE_GREEN_PAD) return GRP_PAD;
        return GRP_CYM;
    endfunction

    // Apply one event to the predicted kit and return the status it reports.
    function automatic t_lane_status advance_kit(input t_drum_event ev);
        t_lane_status         st;
        t_note_role           role;
        logic [LANE_W-1:0]    lane;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] lockout;
        int                   grp;
        int                   i;
        st = '0;
        case (ev.opcode)
            OP_NOTE_ON: begin
                role = note_role(ev.note, lane);
                if (role == ROLE_TOGGLE) begin
                    kit_switch_on = !kit_switch_on;
                end else if (role != ROLE_NONE) begin
                    // The hi-hat notes follow the pedal only while the switch is on.
                    if (role == ROLE_HIHAT)
                        lane = (kit_switch_on && kit_hihat_open) ? LANE_BLUE_CYM
                                                                 : LANE_YELLOW_CYM;
                    grp     = hold_group(int'(lane));
                    age     = kit_now - kit_fire_time[lane];
                    lockout = TIME_BITS'(hold_us[grp]) + TIME_BITS'(holdoff_us[grp]);
                    if (age > lockout) begin
                        kit_active[lane]    = 1'b1;
                        kit_fire_time[lane] = kit_now;
                        st.fired            = 1'b1;
                    end
                end
            end
            OP_CONTROL: begin
                // Pedal hysteresis: closing is tested before opening.
                if (ev.ctl == CTL_PEDAL) begin
                    if (kit_hihat_open && ev.val >= pedal_high)
                        kit_hihat_open = 1'b0;
                    else if (!kit_hihat_open && ev.val <= pedal_low)
                        kit_hihat_open = 1'b1;
                end
            end
            OP_TICK: begin
                kit_now = kit_now + 1'b1;
                for (i = 0; i < NUM_LANES; i++) begin
                    age = kit_now - kit_fire_time[i];
                    if (kit_active[i] && age > TIME_BITS'(hold_us[hold_group(i)]))
                        kit_active[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        st.lane_levels     = kit_active;
        st.hihat_open      = kit_hihat_open;
        st.hihat_switch_on = kit_switch_on;
        return st;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_drum_event random_event();
        t_drum_event ev;
        int          pick;
        ev.note = MIDI_W'($urandom_range(0, 127));
        ev.ctl  = MIDI_W'($urandom_range(0, 127));
        ev.val  = MIDI_W'($urandom_range(0, 127));
        pick    = $urandom_range(0, 99);
        if (pick < 45) begin
            ev.opcode = OP_TICK;
        end else if (pick < 80) begin
            ev.opcode = OP_NOTE_ON;
            if ($urandom_range(0, 99) < 80) ev.note = kit_notes[$urandom_range(0, 15)];
        end else if (pick < 95) begin
            ev.opcode = OP_CONTROL;
            if ($urandom_range(0, 99) < 80) ev.ctl = CTL_PEDAL;
        end else begin
            ev.opcode = OP_RESERVED;
        end
        return ev;
    endfunction

    task automatic push_event(input t_opcode op, input logic [MIDI_W-1:0] note,
                              input logic [MIDI_W-1:0] ctl,
                              input logic [MIDI_W-1:0] val);
        t_drum_event ev;
        ev.opcode = op;
        ev.note   = note;
        ev.ctl    = ctl;
        ev.val    = val;
        pending_events.push_back(ev);
    endtask

    // Write one register and wait for the beat to be taken.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
    endtask

    // Program all eight registers; pedal writes carry noise in the upper bits.
    task automatic program_kit(input logic [HOLD_W-1:0] kick_h, input logic [HOLD_W-1:0] kick_o,
                               input logic [HOLD_W-1:0] pad_h, input logic [HOLD_W-1:0] pad_o,
                               input logic [HOLD_W-1:0] cym_h, input logic [HOLD_W-1:0] cym_o,
                               input logic [MIDI_W-1:0] low, input logic [MIDI_W-1:0] high);
        logic [CFG_DATA_W-1:0] noisy;
        write_reg(CFG_KICK_HOLD, kick_h);
        write_reg(CFG_KICK_HOLDOFF, kick_o);
        write_reg(CFG_PAD_HOLD, pad_h);
        write_reg(CFG_PAD_HOLDOFF, pad_o);
        write_reg(CFG_CYM_HOLD, cym_h);
        write_reg(CFG_CYM_HOLDOFF, cym_o);
        noisy = CFG_DATA_W'($urandom);
        noisy[MIDI_W-1:0] = low;
        write_reg(CFG_PEDAL_LOW, noisy);
        noisy = CFG_DATA_W'($urandom);
        noisy[MIDI_W-1:0] = high;
        write_reg(CFG_PEDAL_HIGH, noisy);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every queued event is taken and every result has come back.
    task automatic settle();
        while (pending_events.size() != 0 || in_if.valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Event driver: presents the next queued beat once the last one is taken.
    always @(negedge i_clk) begin
        t_drum_event ev;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_beat_taken || !in_if.valid) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                ev = pending_events.pop_front();
                in_if.valid          <= 1'b1;
                in_if.opcode         <= ev.opcode;
                in_if.note_number    <= ev.note;
                in_if.control_number <= ev.ctl;
                in_if.control_value  <= ev.val;
                tx_gap_left = (tx_idling && $urandom_range(0, 99) < 35) ? idle_length() : 0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (rx_hold_served != rx_hold_asks) begin
                rx_hold_served = rx_hold_asks;
                rx_stall_left  = LONG_HOLD;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                out_if.ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 99) < 15) begin
                rx_stall_left = idle_length() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: register writes and accepted events feed the predictor,
    // result beats are checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_drum_event  ev;
        t_lane_status want;
        int           i;
        if (!i_rst_n) begin
            in_beat_taken  = 1'b0;
            kit_now        = '0;
            kit_active     = '0;
            kit_hihat_open = 1'b0;
            kit_switch_on  = 1'b1;
            for (i = 0; i < NUM_LANES; i++) kit_fire_time[i] = '0;
            hold_us[GRP_KICK]    = RST_KICK_HOLD;
            holdoff_us[GRP_KICK] = RST_KICK_HOLDOFF;
            hold_us[GRP_PAD]     = RST_PAD_HOLD;
            holdoff_us[GRP_PAD]  = RST_PAD_HOLDOFF;
            hold_us[GRP_CYM]     = RST_CYM_HOLD;
            holdoff_us[GRP_CYM]  = RST_CYM_HOLDOFF;
            pedal_low            = RST_PEDAL_LOW;
            pedal_high           = RST_PEDAL_HIGH;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_index'(cfg_if.index))
                    CFG_KICK_HOLD:    hold_us[GRP_KICK]    = cfg_if.data;
                    CFG_KICK_HOLDOFF: holdoff_us[GRP_KICK] = cfg_if.data;
                    CFG_PAD_HOLD:     hold_us[GRP_PAD]     = cfg_if.data;
                    CFG_PAD_HOLDOFF:  holdoff_us[GRP_PAD]  = cfg_if.data;
                    CFG_CYM_HOLD:     hold_us[GRP_CYM]     = cfg_if.data;
                    CFG_CYM_HOLDOFF:  holdoff_us[GRP_CYM]  = cfg_if.data;
                    CFG_PEDAL_LOW:    pedal_low            = cfg_if.data[MIDI_W-1:0];
                    CFG_PEDAL_HIGH:   pedal_high           = cfg_if.data[MIDI_W-1:0];
                    default: begin
                    end
                endcase
            end
            in_beat_taken = in_if.valid && in_if.ready;
            if (in_beat_taken) begin
                ev.opcode = t_opcode'(in_if.opcode);
                ev.note   = in_if.note_number;
                ev.ctl    = in_if.control_number;
                ev.val    = in_if.control_value;
                expected_status.push_back(advance_kit(ev));
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    32'(out_if.lane_levels), 32'(0));
                end else begin
                    want = expected_status.pop_front();
                    if (out_if.lane_levels !== want.lane_levels)
                        report_mismatch("lane_levels", 32'(out_if.lane_levels),
                                        32'(want.lane_levels));
                    if (out_if.fired !== want.fired)
                        report_mismatch("fired", 32'(out_if.fired), 32'(want.fired));
                    if (out_if.hihat_open !== want.hihat_open)
                        report_mismatch("hihat_open", 32'(out_if.hihat_open),
                                        32'(want.hihat_open));
                    if (out_if.hihat_switch_on !== want.hihat_switch_on)
                        report_mismatch("hihat_switch_on", 32'(out_if.hihat_switch_on),
                                        32'(want.hihat_switch_on));
                end
                result_count++;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) break;
        end
        $display("TIMEOUT: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Main sequence: reset, directed beats, then random phases.
    initial begin
        int phase;
        int n;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.opcode         = OP_TICK;
        in_if.note_number    = '0;
        in_if.control_number = '0;
        in_if.control_value  = '0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_KICK_HOLD;
        cfg_if.data          = '0;
        tx_idling            = 1'b1;
        rx_idling            = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: reserved opcode, unmapped notes, foreign controllers,
        // and a kick that is still locked out right after reset.
        push_event(OP_RESERVED, 7'h7F, 7'h7F, 7'h7F);
        push_event(OP_NOTE_ON, 7'd0, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, 7'h7F, 7'h7F, 7'h7F);
        push_event(OP_NOTE_ON, NOTE_KICK, 7'd0, 7'd0);
        push_event(OP_CONTROL, 7'd0, 7'd0, 7'd0);
        push_event(OP_CONTROL, 7'h7F, 7'h7F, 7'h7F);
        push_event(OP_TICK, 7'h55, 7'h2A, 7'h55);
        settle();

        // Zero hold times: every lane fires, relocks and releases quickly.
        program_kit('0, '0, '0, '0, '0, '0, RST_PEDAL_LOW, RST_PEDAL_HIGH);
        push_event(OP_NOTE_ON, NOTE_KICK, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_KICK, 7'd0, 7'd0);
        push_event(OP_TICK, 7'd0, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_RED_A, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_RED_B, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_YELLOW_PAD, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_BLUE_PAD, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_GREEN_PAD, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_GREEN_A, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_HIHAT_B, 7'd0, 7'd0);
        push_event(OP_CONTROL, 7'd0, CTL_PEDAL, 7'd0);
        push_event(OP_TICK, 7'd0, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_HIHAT_A, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_TOGGLE, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_HIHAT_B, 7'd0, 7'd0);
        push_event(OP_CONTROL, 7'd0, CTL_PEDAL, 7'h7F);
        push_event(OP_NOTE_ON, NOTE_TOGGLE, 7'd0, 7'd0);
        push_event(OP_NOTE_ON, NOTE_BLUE_C, 7'd0, 7'd0);

        // Random phases, each under its own register setting.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                2: begin
                    program_kit(HOLD_W'(1000000), '1, '0, '0, '1, HOLD_W'(1000000),
                                '0, '1);
                end
                5: begin
                    // Crossed thresholds.
                    program_kit(HOLD_W'($urandom_range(0, 6)), HOLD_W'($urandom_range(0, 6)),
                                HOLD_W'($urandom_range(0, 6)), HOLD_W'($urandom_range(0, 6)),
                                HOLD_W'($urandom_range(0, 6)), HOLD_W'($urandom_range(0, 6)),
                                MIDI_W'($urandom_range(90, 127)),
                                MIDI_W'($urandom_range(0, 40)));
                end
                default: begin
                    if (phase % 2 == 1)
                        program_kit(HOLD_W'($urandom_range(10, 60)),
                                    HOLD_W'($urandom_range(0, 20)),
                                    HOLD_W'($urandom_range(10, 60)),
                                    HOLD_W'($urandom_range(0, 20)),
                                    HOLD_W'($urandom_range(10, 60)),
                                    HOLD_W'($urandom_range(0, 20)),
                                    MIDI_W'($urandom_range(0, 127)),
                                    MIDI_W'($urandom_range(0, 127)));
                    else
                        program_kit(HOLD_W'($urandom_range(0, 8)),
                                    HOLD_W'($urandom_range(0, 8)),
                                    HOLD_W'($urandom_range(0, 8)),
                                    HOLD_W'($urandom_range(0, 8)),
                                    HOLD_W'($urandom_range(0, 8)),
                                    HOLD_W'($urandom_range(0, 8)),
                                    MIDI_W'($urandom_range(0, 127)),
                                    MIDI_W'($urandom_range(0, 127)));
                end
            endcase
            // Some phases run back to back with no idling at all.
            tx_idling = (phase % 3 != 1);
            rx_idling = (phase % 3 != 1);
            for (n = 0; n < PHASE_BEATS; n++) pending_events.push_back(random_event());
            // Hold off the receiver while the sender keeps offering beats.
            if (phase == 3) rx_hold_asks++;
        end
        settle();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
